// File: sv/multichannel_fir_filter_defines.svh
// Assertion macros shared by the multichannel FIR filter RTL
`ifndef MULTICHANNEL_FIR_FILTER_DEFINES_SVH
`define MULTICHANNEL_FIR_FILTER_DEFINES_SVH
`ifndef SYNTH
// checked on clk, skipped while rst_n is low
`define MCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on clk, reset included
`define MCF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCF_ASSERT(label, prop, msg)
`define MCF_ASSERT_RST(label, prop, msg)
`endif
`endif

// File: sv/mcf_pkg.sv
// Constants and types of the multichannel FIR filter
`default_nettype none
package mcf_pkg;

  localparam int TAPS         = 41;
  localparam int CHANNELS     = 8;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;

  localparam int COEF_FRAC = COEF_WIDTH - 2;
  localparam int ACC_W     = 64;
  localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;

  localparam int CH_W    = 3;
  localparam int IDX_W   = 6;
  localparam int TAP_W   = $clog2(TAPS);
  localparam int HADDR_W = CH_W + TAP_W;
  localparam int HIST_DEPTH = 1 << HADDR_W;

  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef struct packed {
    logic clr;
    logic rd_v;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic                    done;
    logic                    clipped;
    logic [SAMPLE_WIDTH-1:0] fx;
    logic [SAMPLE_WIDTH-1:0] fy;
  } mac_res_t;

endpackage
`default_nettype wire

// File: sv/mcf_if.sv
// Request and result channel interfaces of the multichannel FIR filter
`default_nettype none
interface mcf_in_if;
  import mcf_pkg::*;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [CH_W-1:0]                channel;
  logic signed [SAMPLE_WIDTH-1:0] sample_x;
  logic signed [SAMPLE_WIDTH-1:0] sample_y;
  logic [IDX_W-1:0]               coef_index;
  logic signed [COEF_WIDTH-1:0]   coef_value;

  modport source (output valid, func, channel, sample_x, sample_y, coef_index, coef_value,
                  input ready);
  modport sink (input valid, func, channel, sample_x, sample_y, coef_index, coef_value,
                output ready);
endinterface

interface mcf_out_if;
  import mcf_pkg::*;
  logic                           valid;
  logic                           ready;
  logic [CH_W-1:0]                out_channel;
  logic signed [SAMPLE_WIDTH-1:0] filtered_x;
  logic signed [SAMPLE_WIDTH-1:0] filtered_y;
  logic                           clipped;

  modport source (output valid, out_channel, filtered_x, filtered_y, clipped, input ready);
  modport sink (input valid, out_channel, filtered_x, filtered_y, clipped, output ready);
endinterface
`default_nettype wire

// File: sv/mcf_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module mcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/mcf_mac.sv
// Shared multiply-accumulate for x and y with rounding and saturation
`default_nettype none
module mcf_mac (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mcf_pkg::mac_ctl_t                       ctl,
  input  logic signed [mcf_pkg::COEF_WIDTH-1:0]   coef,
  input  logic signed [mcf_pkg::SAMPLE_WIDTH-1:0] hist_x,
  input  logic signed [mcf_pkg::SAMPLE_WIDTH-1:0] hist_y,
  output mcf_pkg::mac_res_t                       res
);
  import mcf_pkg::*;

  localparam logic signed [ACC_W-1:0] ONE      = ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ONE <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  = (ONE <<< (SAMPLE_WIDTH - 1)) - ONE;
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - ONE;

  logic                     m_v_r;
  logic                     m_last_r;
  logic                     a_last_r;
  logic signed [PROD_W-1:0] prod_x_nxt;
  logic signed [PROD_W-1:0] prod_y_nxt;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic signed [ACC_W-1:0]  acc_x_r;
  logic signed [ACC_W-1:0]  acc_y_r;
  logic [SAMPLE_WIDTH:0]    sat_x;
  logic [SAMPLE_WIDTH:0]    sat_y;

  // {clip, value}: round half up, arithmetic shift, clamp to sample range
  function automatic logic [SAMPLE_WIDTH:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shf;
    logic [SAMPLE_WIDTH:0]   r;
    rnd = acc + RND_HALF;
    shf = rnd >>> COEF_FRAC;
    if (shf > SAT_MAX) begin
      r = {1'b1, SAT_MAX[SAMPLE_WIDTH-1:0]};
    end else if (shf < SAT_MIN) begin
      r = {1'b1, SAT_MIN[SAMPLE_WIDTH-1:0]};
    end else begin
      r = {1'b0, shf[SAMPLE_WIDTH-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    prod_x_nxt = coef * hist_x;
    prod_y_nxt = coef * hist_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r    <= 1'b0;
      m_last_r <= 1'b0;
      a_last_r <= 1'b0;
    end else begin
      m_v_r    <= ctl.rd_v;
      m_last_r <= ctl.last;
      a_last_r <= m_v_r && m_last_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
    if (ctl.clr) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (m_v_r) begin
      acc_x_r <= acc_x_r + ACC_W'(prod_x_r);
      acc_y_r <= acc_y_r + ACC_W'(prod_y_r);
    end
  end

  always_comb begin
    sat_x       = round_sat(acc_x_r);
    sat_y       = round_sat(acc_y_r);
    res.done    = a_last_r;
    res.clipped = sat_x[SAMPLE_WIDTH] | sat_y[SAMPLE_WIDTH];
    res.fx      = sat_x[SAMPLE_WIDTH-1:0];
    res.fy      = sat_y[SAMPLE_WIDTH-1:0];
  end
endmodule
`default_nettype wire

// File: sv/multichannel_fir_filter.sv
// Sample request: accepted while idle; the result follows the tap walk (S_RUN), the MAC pipeline
// and S_DRAIN. The next request is taken once the result is loaded into the output register; the
// single shared MAC walks one tap per cycle out of the history RAM, and a held result waits in S_DONE.
// Coefficient request: taken while idle, no result.
// Reset (rst_n low, synchronous) starts a clearing pass over history and coefficient RAMs,
// all HIST_DEPTH = 512 history entries, during which no request is taken.
`default_nettype none
`include "multichannel_fir_filter_defines.svh"
module multichannel_fir_filter (
  input  logic     clk,
  input  logic     rst_n,
  mcf_in_if.sink   in_req,
  mcf_out_if.source out_res
);
  import mcf_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

  state_t                  state_r;
  logic [HADDR_W-1:0]      clr_cnt_r;
  logic [TAP_W-1:0]        tap_r;
  logic [TAP_W-1:0]        ptr_r;
  logic [CH_W-1:0]         ch_r;
  logic [TAP_W-1:0]        head_r [1 << CH_W];
  logic                    rd_v_r;
  logic                    last_r;
  logic                    out_valid_r;
  logic [CH_W-1:0]         out_ch_r;
  logic [SAMPLE_WIDTH-1:0] out_x_r;
  logic [SAMPLE_WIDTH-1:0] out_y_r;
  logic                    out_clip_r;

  logic                      acc_in;
  logic                      start;
  logic                      coef_wr;
  logic                      slot_free;
  logic                      load_out;
  logic [TAP_W-1:0]          head_cur;
  logic [TAP_W-1:0]          new_head;
  logic [TAP_W-1:0]          ptr_inc;
  logic                      h_we;
  logic [HADDR_W-1:0]        h_waddr;
  logic [2*SAMPLE_WIDTH-1:0] h_wdata;
  logic [2*SAMPLE_WIDTH-1:0] h_rdata;
  logic                      c_we;
  logic [TAP_W-1:0]          c_waddr;
  logic [COEF_WIDTH-1:0]     c_wdata;
  logic [COEF_WIDTH-1:0]     c_rdata;
  mac_ctl_t                  mac_ctl;
  mac_res_t                  res;

  assign acc_in    = in_req.valid && in_req.ready;
  assign start     = acc_in && (in_req.func == FUNC_SAMPLE) && (int'(in_req.channel) < CHANNELS);
  assign coef_wr   = acc_in && (in_req.func == FUNC_COEF) && (int'(in_req.coef_index) < TAPS);
  assign slot_free = !out_valid_r || out_res.ready;
  assign load_out  = slot_free && ((state_r == S_DRAIN && res.done) || state_r == S_DONE);
  assign head_cur  = head_r[in_req.channel];
  // circular history: newest sample sits at head, tap t at (head + t) mod TAPS
  assign new_head  = (head_cur == '0) ? TAP_LAST : head_cur - 1'b1;
  assign ptr_inc   = (ptr_r == TAP_LAST) ? '0 : ptr_r + 1'b1;

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_res.valid       = out_valid_r;
  assign out_res.out_channel = out_ch_r;
  assign out_res.filtered_x  = out_x_r;
  assign out_res.filtered_y  = out_y_r;
  assign out_res.clipped     = out_clip_r;

  always_comb begin
    if (state_r == S_CLEAR) begin
      h_we    = 1'b1;
      h_waddr = clr_cnt_r;
      h_wdata = '0;
      c_we    = int'(clr_cnt_r[TAP_W-1:0]) < TAPS;
      c_waddr = clr_cnt_r[TAP_W-1:0];
      c_wdata = '0;
    end else begin
      h_we    = start;
      h_waddr = {in_req.channel, new_head};
      h_wdata = {in_req.sample_x, in_req.sample_y};
      c_we    = coef_wr;
      c_waddr = TAP_W'(in_req.coef_index);
      c_wdata = in_req.coef_value;
    end
  end

  mcf_ram #(.WIDTH(2 * SAMPLE_WIDTH), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr ({ch_r, ptr_r}),
    .rdata (h_rdata)
  );

  mcf_ram #(.WIDTH(COEF_WIDTH), .DEPTH(TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (tap_r),
    .rdata (c_rdata)
  );

  assign mac_ctl = '{clr: start, rd_v: rd_v_r, last: last_r};

  mcf_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .coef   ($signed(c_rdata)),
    .hist_x ($signed(h_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .hist_y ($signed(h_rdata[SAMPLE_WIDTH-1:0])),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      tap_r       <= '0;
      ptr_r       <= '0;
      ch_r        <= '0;
      head_r      <= '{default: '0};
      rd_v_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= (state_r == S_RUN);
      last_r <= (state_r == S_RUN) && (tap_r == TAP_LAST);
      // a new result replaces the one taken in the same cycle
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            head_r[in_req.channel] <= new_head;
            ch_r    <= in_req.channel;
            ptr_r   <= new_head;
            tap_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          ptr_r <= ptr_inc;
          tap_r <= tap_r + 1'b1;
          if (tap_r == TAP_LAST) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (res.done) begin
            if (slot_free) begin
              out_ch_r    <= ch_r;
              out_x_r     <= res.fx;
              out_y_r     <= res.fy;
              out_clip_r  <= res.clipped;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // accumulators hold until the next request clears them
          if (slot_free) begin
            out_ch_r    <= ch_r;
            out_x_r     <= res.fx;
            out_y_r     <= res.fy;
            out_clip_r  <= res.clipped;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MCF_ASSERT_RST(a_reset_clears, !rst_n |=> state_r == S_CLEAR, "reset did not start clear pass")
  `MCF_ASSERT(a_ptr_range, ptr_r <= TAP_LAST, "history pointer past last tap")
  `MCF_ASSERT(a_ptr_wrap, last_r |-> ptr_r == head_r[ch_r], "tap walk not aligned with head")
  `MCF_ASSERT(a_done_in_drain, res.done |-> state_r == S_DRAIN, "MAC finished outside drain")
  `MCF_ASSERT(a_out_load, $rose(out_valid_r) |-> $past(res.done || state_r == S_DONE), "no sum")
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the multichannel FIR filter: directed table, then random requests
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcf_pkg::*;

  typedef struct packed {
    logic                    func;
    logic [CH_W-1:0]         channel;
    logic [SAMPLE_WIDTH-1:0] sx;
    logic [SAMPLE_WIDTH-1:0] sy;
    logic [IDX_W-1:0]        idx;
    logic [COEF_WIDTH-1:0]   cv;
  } fir_req_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic [SAMPLE_WIDTH-1:0] fx;
    logic [SAMPLE_WIDTH-1:0] fy;
    logic                    clipped;
  } fir_out_t;

  typedef struct packed {
    fir_req_t req;
    logic     known;   // typed-in output below is used instead of the predictor's
    fir_out_t res;
  } dir_row_t;

  localparam int DIR_N        = 23;
  localparam int RAND_ITEMS   = 430;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 60;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty coefficient table: everything filters to zero
    '{'{FUNC_SAMPLE, 3'd0, 16'h7FFF, 16'h8000, 6'd63, 16'hFFFF}, 1'b1,
      '{3'd0, 16'd0, 16'd0, 1'b0}},
    '{'{FUNC_COEF, 3'd7, 16'hFFFF, 16'hFFFF, 6'd0, 16'd16384}, 1'b0, '0},
    // unity tap 0 passes the newest sample through
    '{'{FUNC_SAMPLE, 3'd1, 16'h7FFF, 16'h8000, 6'd0, 16'd0}, 1'b1,
      '{3'd1, 16'h7FFF, 16'h8000, 1'b0}},
    '{'{FUNC_SAMPLE, 3'd0, 16'd1234, -16'sd1, 6'd0, 16'd0}, 1'b1,
      '{3'd0, 16'd1234, -16'sd1, 1'b0}},
    // taps out of range are dropped
    '{'{FUNC_COEF, 3'd0, 16'd0, 16'd0, 6'd63, 16'hFFFF}, 1'b0, '0},
    '{'{FUNC_COEF, 3'd0, 16'd0, 16'd0, 6'd41, 16'h7FFF}, 1'b0, '0},
    '{'{FUNC_SAMPLE, 3'd0, 16'd5, 16'd6, 6'd41, 16'h7FFF}, 1'b1,
      '{3'd0, 16'd5, 16'd6, 1'b0}},
    // -2.0 on tap 0 drives both rails
    '{'{FUNC_COEF, 3'd0, 16'd0, 16'd0, 6'd0, 16'h8000}, 1'b0, '0},
    '{'{FUNC_SAMPLE, 3'd7, 16'h8000, 16'h7FFF, 6'd0, 16'd0}, 1'b1,
      '{3'd7, 16'h7FFF, 16'h8000, 1'b1}},
    '{'{FUNC_SAMPLE, 3'd7, 16'd16383, -16'sd16384, 6'd0, 16'd0}, 1'b1,
      '{3'd7, -16'sd32766, 16'h7FFF, 1'b1}},
    // 0.5 on tap 0: half-LSB ties round up
    '{'{FUNC_COEF, 3'd0, 16'd0, 16'd0, 6'd0, 16'd8192}, 1'b0, '0},
    '{'{FUNC_SAMPLE, 3'd3, 16'd1, -16'sd1, 6'd0, 16'd0}, 1'b1,
      '{3'd3, 16'd1, 16'd0, 1'b0}},
    '{'{FUNC_SAMPLE, 3'd3, 16'd3, -16'sd3, 6'd0, 16'd0}, 1'b1,
      '{3'd3, 16'd2, -16'sd1, 1'b0}},
    '{'{FUNC_COEF, 3'd0, 16'd0, 16'd0, 6'd40, 16'h7FFF}, 1'b0, '0},
    '{'{FUNC_COEF, 3'd0, 16'd0, 16'd0, 6'd1, 16'h8000}, 1'b0, '0},
    '{'{FUNC_SAMPLE, 3'd3, 16'h8000, 16'h7FFF, 6'd0, 16'd0}, 1'b0, '0},
    '{'{FUNC_SAMPLE, 3'd4, 16'd0, 16'd0, 6'd0, 16'd0}, 1'b1,
      '{3'd4, 16'd0, 16'd0, 1'b0}},
    '{'{FUNC_COEF, 3'd0, 16'd0, 16'd0, 6'd20, 16'd4096}, 1'b0, '0},
    '{'{FUNC_SAMPLE, 3'd2, 16'd21845, 16'hAAAA, 6'd0, 16'd0}, 1'b0, '0},
    '{'{FUNC_SAMPLE, 3'd5, 16'hFFFF, 16'd1, 6'd0, 16'd0}, 1'b0, '0},
    '{'{FUNC_SAMPLE, 3'd6, 16'h5555, 16'hAAAA, 6'd0, 16'd0}, 1'b0, '0},
    '{'{FUNC_COEF, 3'd0, 16'd0, 16'd0, 6'd40, 16'h8000}, 1'b0, '0},
    '{'{FUNC_SAMPLE, 3'd6, 16'h8000, 16'h7FFF, 6'd0, 16'd0}, 1'b0, '0}
  };

  logic clk;
  logic rst_n    = 1'b0;
  logic rx_ready = 1'b0;
  logic rx_hold  = 1'b0;

  mcf_in_if  in_req();
  mcf_out_if out_res();

  assign out_res.ready = rx_ready;

  multichannel_fir_filter DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predictor state
  logic [SAMPLE_WIDTH-1:0] hist_x   [CHANNELS][TAPS];
  logic [SAMPLE_WIDTH-1:0] hist_y   [CHANNELS][TAPS];
  logic [COEF_WIDTH-1:0]   coef_tab [TAPS];

  fir_out_t filtered_q[$];
  int       n_err     = 0;
  int       n_sent    = 0;
  int       n_results = 0;
  int       rx_wait   = 0;
  int       rx_stall;
  logic     quiet_tx  = 1'b0;
  logic     quiet_rx  = 1'b0;

  function automatic logic [SAMPLE_WIDTH-1:0] tap_sum(input int ch, input logic use_y,
                                                      inout logic clip);
    longint acc;
    longint maxv;
    longint minv;
    acc = 0;
    for (int t = 0; t < TAPS; t++) begin
      acc += longint'($signed(coef_tab[t])) *
             longint'($signed(use_y ? hist_y[ch][t] : hist_x[ch][t]));
    end
    acc  = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    maxv = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    minv = -maxv - 1;
    if (acc > maxv) begin
      acc  = maxv;
      clip = 1'b1;
    end else if (acc < minv) begin
      acc  = minv;
      clip = 1'b1;
    end
    return acc[SAMPLE_WIDTH-1:0];
  endfunction

  // returns 1 when the request produces a filtered output
  function automatic logic fir_step(input fir_req_t r, output fir_out_t o);
    logic clip;
    int   ch;
    clip = 1'b0;
    ch   = int'(r.channel);
    o    = '0;
    if (r.func == FUNC_COEF) begin
      if (int'(r.idx) < TAPS) coef_tab[r.idx] = r.cv;
      return 1'b0;
    end
    if (ch >= CHANNELS) return 1'b0;
    for (int t = TAPS - 1; t > 0; t--) begin
      hist_x[ch][t] = hist_x[ch][t-1];
      hist_y[ch][t] = hist_y[ch][t-1];
    end
    hist_x[ch][0] = r.sx;
    hist_y[ch][0] = r.sy;
    o.channel = r.channel;
    o.fx      = tap_sum(ch, 1'b0, clip);
    o.fy      = tap_sum(ch, 1'b1, clip);
    o.clipped = clip;
    return 1'b1;
  endfunction

  // append one awaited output to the scoreboard queue
  function automatic void log_expected(input fir_out_t o);
    filtered_q = {filtered_q, o};
  endfunction

  function automatic fir_req_t random_request();
    fir_req_t r;
    r.func    = ($urandom_range(0, 99) < 28) ? FUNC_COEF : FUNC_SAMPLE;
    r.channel = CH_W'($urandom);
    r.sx      = SAMPLE_WIDTH'($urandom);
    r.sy      = SAMPLE_WIDTH'($urandom);
    r.idx     = IDX_W'($urandom);
    r.cv      = COEF_WIDTH'($urandom);
    if (r.func == FUNC_COEF) begin
      if ($urandom_range(0, 9) != 0) r.idx = IDX_W'($urandom_range(0, TAPS - 1));
      // mostly small coefficients so that sums land both inside and outside the range
      r.cv = COEF_WIDTH'($signed(r.cv) >>> $urandom_range(0, 7));
    end else if ($urandom_range(0, 1) == 1) begin
      r.sx = SAMPLE_WIDTH'($signed(r.sx) >>> $urandom_range(0, 6));
      r.sy = SAMPLE_WIDTH'($signed(r.sy) >>> $urandom_range(0, 6));
    end
    return r;
  endfunction

  task automatic report(input string what, input fir_out_t want, input fir_out_t got);
    n_err++;
    if (n_err <= 10) begin
      $display("%0t: %s: expected ch=%0d x=%0d y=%0d clip=%0d, got ch=%0d x=%0d y=%0d clip=%0d",
               $realtime, what, want.channel, $signed(want.fx), $signed(want.fy),
               want.clipped, got.channel, $signed(got.fx), $signed(got.fy), got.clipped);
    end
  endtask

  task automatic check_output(input fir_out_t got);
    fir_out_t want;
    if (filtered_q.size() == 0) begin
      report("output with no request pending", '0, got);
    end else begin
      want = filtered_q.pop_front();
      if (got.channel !== want.channel) report("channel mismatch", want, got);
      else if (got.fx !== want.fx) report("filtered_x mismatch", want, got);
      else if (got.fy !== want.fy) report("filtered_y mismatch", want, got);
      else if (got.clipped !== want.clipped) report("clipped mismatch", want, got);
    end
  endtask

  // one request: optional idle gap, then hold valid until it is taken
  task automatic offer(input fir_req_t r, input int gap);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.func       <= r.func;
    in_req.channel    <= r.channel;
    in_req.sample_x   <= r.sx;
    in_req.sample_y   <= r.sy;
    in_req.coef_index <= r.idx;
    in_req.coef_value <= r.cv;
    in_req.valid      <= 1'b1;
    do @(posedge clk); while (!in_req.ready);
    n_sent++;
    if (n_sent % 32 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
  endtask

  // result side: per-output stall, plus the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ready <= 1'b0;
      rx_wait  <= 0;
    end else if (out_res.valid && out_res.ready) begin
      check_output('{out_res.out_channel, out_res.filtered_x, out_res.filtered_y,
                     out_res.clipped});
      n_results++;
      if (n_results % 32 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
      rx_stall = quiet_rx ? 0 : $urandom_range(0, 12);
      if (rx_stall == 0 && !rx_hold) begin
        rx_ready <= 1'b1;
      end else begin
        rx_ready <= 1'b0;
        rx_wait  <= rx_stall;
      end
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_ready <= !rx_hold;
    end
  end

  initial begin
    wait (n_sent >= 150);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #400_000;
    $display("multichannel_fir_filter verification failed");
    $finish;
  end

  initial begin
    fir_req_t r;
    fir_out_t o;
    int       n_rand;
    logic     has_out;
    n_rand = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int t = 0; t < TAPS; t++) begin
        hist_x[c][t] = '0;
        hist_y[c][t] = '0;
      end
    end
    for (int t = 0; t < TAPS; t++) coef_tab[t] = '0;
    in_req.valid      <= 1'b0;
    in_req.func       <= FUNC_SAMPLE;
    in_req.channel    <= '0;
    in_req.sample_x   <= '0;
    in_req.sample_y   <= '0;
    in_req.coef_index <= '0;
    in_req.coef_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      offer(DIR_ROWS[i].req, quiet_tx ? 0 : $urandom_range(0, 12));
      has_out = fir_step(DIR_ROWS[i].req, o);
      if (has_out) log_expected(DIR_ROWS[i].known ? DIR_ROWS[i].res : o);
    end

    while (n_rand < RAND_ITEMS) begin
      r = random_request();
      offer(r, quiet_tx ? 0 : $urandom_range(0, 12));
      has_out = fir_step(r, o);
      if (has_out) log_expected(o);
      if (r.func == FUNC_SAMPLE || int'(r.idx) < TAPS) n_rand++;
    end
    in_req.valid <= 1'b0;

    wait (filtered_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0 && filtered_q.size() == 0) begin
      $display("multichannel_fir_filter verification clean");
    end else begin
      $display("multichannel_fir_filter verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: multichannel_fir_filter.f
+incdir+sv
sv/mcf_pkg.sv
sv/mcf_if.sv
sv/mcf_ram.sv
sv/mcf_mac.sv
sv/multichannel_fir_filter.sv
tb/sv/tb.sv
